// ===== rtl/core/gga_pkg.sv =====
// Shared types, character codes, field map and constant tables for the GGA parser.
// No dependencies; imported by every module of the block.
package gga_pkg;

  localparam int DEF_FRAC  = 5;
  localparam int MAX_FRAC  = 7;
  localparam int NUM_SLOTS = 7;

  // Accumulator width covers the position clamp at the largest fraction setting.
  localparam int ACC_W      = 30;
  localparam int DEG_W      = 10;
  localparam int MAG_W      = 31;
  localparam int LIM_W      = 27;
  localparam int DEGTERM_W  = 34;

  // Character codes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;

  // Field numbers within a GGA line
  localparam logic [4:0] FLD_HDR    = 5'd0;
  localparam logic [4:0] FLD_LAT    = 5'd2;
  localparam logic [4:0] FLD_NS     = 5'd3;
  localparam logic [4:0] FLD_LON    = 5'd4;
  localparam logic [4:0] FLD_EW     = 5'd5;
  localparam logic [4:0] FLD_FIX    = 5'd6;
  localparam logic [4:0] FLD_SAT    = 5'd7;
  localparam logic [4:0] FLD_HDOP   = 5'd8;
  localparam logic [4:0] FLD_ALT    = 5'd9;
  localparam logic [4:0] FLD_GEOID  = 5'd11;
  localparam logic [4:0] MIN_FIELDS = 5'd15;
  localparam logic [4:0] CNT_MAX    = 5'd31;
  localparam logic [4:0] HDR_LAST   = 5'd5;

  localparam logic [30:0] LAT_LIM = 31'd900000000;
  localparam logic [30:0] LON_LIM = 31'd1800000000;
  localparam logic [ACC_W-1:0] NUM_CLAMP = ACC_W'(100000001);

  typedef enum logic [1:0] {
    MODE_HDR,
    MODE_BODY,
    MODE_SKIP
  } mode_t;

  typedef enum logic [2:0] {
    SLOT_LAT,
    SLOT_LON,
    SLOT_FIX,
    SLOT_SAT,
    SLOT_HDOP,
    SLOT_ALT,
    SLOT_GEOID,
    SLOT_NONE
  } slot_t;

  typedef struct packed {
    slot_t      slot;
    logic [1:0] deg_digits;
    logic [2:0] places;
    logic       sgn;
  } field_info_t;

  typedef struct packed {
    logic bad;
    logic dot;
    logic neg;
    logic dig;
  } field_flags_t;

  typedef struct packed {
    logic hdrbad;
    logic hlat;
    logic hlat_s;
    logic hlon;
    logic hlon_w;
  } line_flags_t;

  typedef struct packed {
    logic             valid;
    logic             is_lon;
    logic [DEG_W-1:0] deg;
    logic [ACC_W-1:0] acc;
    logic [2:0]       frac_exp;
  } pos_req_t;

  typedef struct packed {
    logic             valid;
    logic             is_lon;
    logic [MAG_W-1:0] mag;
  } pos_rsp_t;

  typedef struct packed {
    logic        ok;
    logic [30:0] lat;
    logic [31:0] lon;
    logic [7:0]  fix;
    logic [6:0]  sat;
    logic [13:0] hdop;
    logic [27:0] alt;
    logic [20:0] geoid;
  } res_t;

  // Elaboration-time power of ten.
  function automatic logic [63:0] pow10(input int n);
    logic [63:0] r;
    r = 64'd1;
    for (int i = 0; i < n; i++) r = r * 64'd10;
    return r;
  endfunction

  function automatic logic [23:0] pow10_tab(input logic [2:0] e);
    logic [23:0] r;
    case (e)
      3'd0: r = 24'd1;
      3'd1: r = 24'd10;
      3'd2: r = 24'd100;
      3'd3: r = 24'd1000;
      3'd4: r = 24'd10000;
      3'd5: r = 24'd100000;
      3'd6: r = 24'd1000000;
      3'd7: r = 24'd10000000;
      default: r = 24'd1;
    endcase
    return r;
  endfunction

  function automatic field_info_t field_info(input logic [4:0] fn, input logic [2:0] frac);
    field_info_t fi;
    fi.slot       = SLOT_NONE;
    fi.deg_digits = 2'd0;
    fi.places     = 3'd2;
    fi.sgn        = 1'b0;
    case (fn)
      FLD_LAT: begin
        fi.slot = SLOT_LAT; fi.deg_digits = 2'd2; fi.places = frac;
      end
      FLD_LON: begin
        fi.slot = SLOT_LON; fi.deg_digits = 2'd3; fi.places = frac;
      end
      FLD_FIX: begin
        fi.slot = SLOT_FIX; fi.places = 3'd0;
      end
      FLD_SAT: begin
        fi.slot = SLOT_SAT; fi.places = 3'd0;
      end
      FLD_HDOP: fi.slot = SLOT_HDOP;
      FLD_ALT: begin
        fi.slot = SLOT_ALT; fi.sgn = 1'b1;
      end
      FLD_GEOID: begin
        fi.slot = SLOT_GEOID; fi.sgn = 1'b1;
      end
      default: fi.slot = SLOT_NONE;
    endcase
    return fi;
  endfunction

  function automatic logic [LIM_W-1:0] slot_limit(input slot_t s);
    logic [LIM_W-1:0] r;
    case (s)
      SLOT_FIX:   r = LIM_W'(255);
      SLOT_SAT:   r = LIM_W'(99);
      SLOT_HDOP:  r = LIM_W'(9999);
      SLOT_ALT:   r = LIM_W'(100000000);
      SLOT_GEOID: r = LIM_W'(1000000);
      default:    r = '0;
    endcase
    return r;
  endfunction

  // Talker header: "$GPGGA" or "$GNGGA".
  function automatic logic hdr_match(input logic [4:0] p, input logic [7:0] c);
    logic m;
    case (p)
      5'd0:    m = (c == CH_DOLLAR);
      5'd1:    m = (c == CH_G);
      5'd2:    m = (c == CH_P) || (c == CH_N);
      5'd3:    m = (c == CH_G);
      5'd4:    m = (c == CH_G);
      5'd5:    m = (c == CH_A);
      default: m = 1'b0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/gga_pos_conv.sv =====
// Latitude/longitude converter: degrees plus minutes into 1e-7 degree magnitude.
// Five register stages; depends on gga_pkg.
module gga_pos_conv import gga_pkg::*; #(
  parameter int FRACTION_DIGITS = DEF_FRAC
) (
  input  logic     clk,
  input  logic     rst,
  input  pos_req_t req,
  output pos_rsp_t rsp
);

  localparam logic [ACC_W-1:0] CAP_M     = ACC_W'(pow10(FRACTION_DIGITS + 2));
  localparam logic [23:0]      SCALE     = 24'(pow10(MAX_FRAC - FRACTION_DIGITS));
  localparam logic [23:0]      E7        = 24'd10000000;
  localparam logic [29:0]      RECIP_15  = 30'd572662307;
  localparam int               PROD1_W   = ACC_W + 24;
  localparam int               X_W       = 30;
  localparam int               PROD3_W   = 58;
  localparam int               Q_W       = 25;
  localparam int               SUM_W     = DEGTERM_W + 1;

  // stage 0: capture
  logic             s0_valid, s0_lon;
  logic [DEG_W-1:0] s0_deg;
  logic [ACC_W-1:0] s0_acc;
  logic [2:0]       s0_exp;
  // stage 1: scaled minutes, degree term
  logic                 s1_valid, s1_lon;
  logic [ACC_W-1:0]     s1_m;
  logic [DEGTERM_W-1:0] s1_degterm;
  // stage 2: minutes in 1e-7 units plus half of the divisor
  logic                 s2_valid, s2_lon;
  logic [X_W-1:0]       s2_x;
  logic [DEGTERM_W-1:0] s2_degterm;
  // stage 3: quotient by 60
  logic                 s3_valid, s3_lon;
  logic [Q_W-1:0]       s3_q;
  logic [DEGTERM_W-1:0] s3_degterm;
  // stage 4: result
  logic             s4_valid, s4_lon;
  logic [MAG_W-1:0] s4_mag;

  logic [PROD1_W-1:0]   prod1;
  logic [ACC_W-1:0]     m1;
  logic [PROD1_W-1:0]   prod2;
  logic [PROD3_W-1:0]   prod3;
  logic [SUM_W-1:0]     sum4;
  logic [MAG_W-1:0]     lim4;

  assign prod1 = PROD1_W'(s0_acc) * PROD1_W'(pow10_tab(s0_exp));
  assign m1    = (prod1 > PROD1_W'(CAP_M)) ? CAP_M : prod1[ACC_W-1:0];
  assign prod2 = PROD1_W'(s1_m) * PROD1_W'(SCALE) + PROD1_W'(30);
  // x/60 = (x/4)/15, the /15 by reciprocal multiply (exact for x below 2^30)
  assign prod3 = PROD3_W'(s2_x[X_W-1:2]) * PROD3_W'(RECIP_15);
  assign sum4  = SUM_W'(s3_degterm) + SUM_W'(s3_q);
  assign lim4  = s3_lon ? LON_LIM : LAT_LIM;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s0_valid <= req.valid;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
    s0_lon     <= req.is_lon;
    s0_deg     <= req.deg;
    s0_acc     <= req.acc;
    s0_exp     <= req.frac_exp;
    s1_lon     <= s0_lon;
    s1_m       <= m1;
    s1_degterm <= DEGTERM_W'(s0_deg) * DEGTERM_W'(E7);
    s2_lon     <= s1_lon;
    s2_x       <= prod2[X_W-1:0];
    s2_degterm <= s1_degterm;
    s3_lon     <= s2_lon;
    s3_q       <= prod3[PROD3_W-1:33];
    s3_degterm <= s2_degterm;
    s4_lon     <= s3_lon;
    s4_mag     <= (sum4 > SUM_W'(lim4)) ? lim4 : sum4[MAG_W-1:0];
  end

  assign rsp.valid  = s4_valid;
  assign rsp.is_lon = s4_lon;
  assign rsp.mag    = s4_mag;

endmodule

// ===== rtl/core/gga_char_core.sv =====
// Per-character line and field parser with pending and committed value stores.
// Depends on gga_pkg; hands position fields to gga_pos_conv through pos_req/pos_rsp.
module gga_char_core import gga_pkg::*; #(
  parameter int FRACTION_DIGITS = DEF_FRAC
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] char_byte,
  output logic       push,
  output res_t       result,
  output pos_req_t   pos_req,
  input  pos_rsp_t   pos_rsp
);

  localparam logic [2:0]       FRAC_PL   = 3'(FRACTION_DIGITS);
  localparam logic [ACC_W-1:0] POS_CLAMP = ACC_W'(pow10(FRACTION_DIGITS + 2) + 64'd1);
  localparam int               ACCX_W    = ACC_W + 4;
  localparam int               SCL_W     = ACC_W + 7;
  localparam logic [NUM_SLOTS-1:0] DIRECT_SLOTS = 7'h7C;

  mode_t mode, mode_next;
  logic [4:0]         char_position, char_position_next;
  logic [4:0]         field_number, field_number_next;
  logic [DEG_W-1:0]   degree_acc, degree_acc_next;
  logic [ACC_W-1:0]   value_acc, value_acc_next;
  field_flags_t       field_flags, field_flags_next;
  logic [2:0]         frac_taken, frac_taken_next;
  logic [7:0]         first_char, first_char_next;
  line_flags_t        line_flags, line_flags_next;
  logic [NUM_SLOTS-1:0] present_mask, present_mask_next;
  logic [NUM_SLOTS-1:0] error_mask, error_mask_next;
  logic [31:0]        pending [NUM_SLOTS];
  logic [31:0]        pending_next [NUM_SLOTS];
  logic [31:0]        kept [NUM_SLOTS];
  logic [31:0]        kept_next [NUM_SLOTS];

  field_info_t        info;
  logic               digit;
  logic [3:0]         dval;
  logic [ACCX_W-1:0]  acc_dig;
  logic [ACC_W-1:0]   acc_clamp;
  logic [ACC_W-1:0]   acc_new;
  logic [DEG_W-1:0]   deg_new;
  logic [2:0]         num_exp;
  logic [SCL_W-1:0]   num_scaled;
  logic [LIM_W-1:0]   num_lim;
  logic [LIM_W-1:0]   num_sat;
  logic [31:0]        num_val;
  logic [NUM_SLOTS-1:0] used_mask;
  logic               tokens_ok;
  logic               line_ok;
  logic               commit_ok;

  assign info    = field_info(field_number, FRAC_PL);
  assign digit   = char_byte inside {[CH_ZERO:CH_NINE]};
  assign dval    = char_byte[3:0];
  assign acc_dig = ACCX_W'(value_acc) * ACCX_W'(10) + ACCX_W'(dval);
  assign acc_clamp = (info.slot == SLOT_LAT || info.slot == SLOT_LON) ? POS_CLAMP : NUM_CLAMP;
  // saturate the digit accumulator; clamping is monotone so the final compare is unchanged
  assign acc_new = (acc_dig > ACCX_W'(acc_clamp)) ? acc_clamp : acc_dig[ACC_W-1:0];
  assign deg_new = DEG_W'(14'(degree_acc) * 14'd10 + 14'(dval));

  // pad missing fraction digits, then saturate to the field's range
  assign num_exp = info.places - frac_taken;
  always_comb begin
    case (num_exp)
      3'd2:    num_scaled = SCL_W'(value_acc) * SCL_W'(100);
      3'd1:    num_scaled = SCL_W'(value_acc) * SCL_W'(10);
      default: num_scaled = SCL_W'(value_acc);
    endcase
  end
  assign num_lim = slot_limit(info.slot);
  assign num_sat = (num_scaled > SCL_W'(num_lim)) ? num_lim : num_scaled[LIM_W-1:0];
  assign num_val = field_flags.neg ? (32'd0 - 32'(num_sat)) : 32'(num_sat);

  // a position counts only together with its hemisphere field
  assign used_mask = (present_mask & DIRECT_SLOTS)
                   | {5'b0, present_mask[SLOT_LON] & line_flags.hlon,
                      present_mask[SLOT_LAT] & line_flags.hlat};
  assign tokens_ok = (field_number >= MIN_FIELDS)
                   || (field_number == MIN_FIELDS - 5'd1 && char_position != 5'd0);
  assign line_ok   = !line_flags.hdrbad && tokens_ok && ((used_mask & error_mask) == '0);

  always_comb begin
    mode_next          = mode;
    char_position_next = char_position;
    field_number_next  = field_number;
    degree_acc_next    = degree_acc;
    value_acc_next     = value_acc;
    field_flags_next   = field_flags;
    frac_taken_next    = frac_taken;
    first_char_next    = first_char;
    line_flags_next    = line_flags;
    present_mask_next  = present_mask;
    error_mask_next    = error_mask;
    pending_next       = pending;
    kept_next          = kept;
    push               = 1'b0;
    commit_ok          = 1'b0;
    pos_req            = '0;

    if (fire) begin
      case (mode)
        MODE_SKIP: begin
          if (char_byte == CH_NL) begin
            mode_next          = MODE_HDR;
            char_position_next = '0;
          end
        end
        MODE_BODY: begin
          if (char_byte == CH_COMMA) begin
            // close the field
            if (char_position != 5'd0) begin
              if (field_number == FLD_NS) begin
                line_flags_next.hlat = 1'b1;
                if (char_position == 5'd1 && first_char == CH_S) line_flags_next.hlat_s = 1'b1;
              end else if (field_number == FLD_EW) begin
                line_flags_next.hlon = 1'b1;
                if (char_position == 5'd1 && first_char == CH_W) line_flags_next.hlon_w = 1'b1;
              end else if (info.slot != SLOT_NONE) begin
                present_mask_next[info.slot] = 1'b1;
                if (field_flags.bad || !field_flags.dig) error_mask_next[info.slot] = 1'b1;
                if (info.slot == SLOT_LAT || info.slot == SLOT_LON) begin
                  pos_req.valid    = 1'b1;
                  pos_req.is_lon   = (info.slot == SLOT_LON);
                  pos_req.deg      = degree_acc;
                  pos_req.acc      = value_acc;
                  pos_req.frac_exp = num_exp;
                end else begin
                  pending_next[info.slot] = num_val;
                end
              end
            end
            if (field_number != CNT_MAX) field_number_next = field_number + 5'd1;
            char_position_next = '0;
            degree_acc_next    = '0;
            value_acc_next     = '0;
            field_flags_next   = '0;
            frac_taken_next    = '0;
            first_char_next    = '0;
          end else if (char_byte != CH_NL) begin
            // ordinary character of the current field
            if (field_number == FLD_HDR) line_flags_next.hdrbad = 1'b1;
            if (char_position == 5'd0) first_char_next = char_byte;
            if (info.slot != SLOT_NONE) begin
              if (5'(info.deg_digits) > char_position) begin
                if (digit) degree_acc_next = deg_new;
                else field_flags_next.bad = 1'b1;
              end else if (digit) begin
                field_flags_next.dig = 1'b1;
                if (!field_flags.dot) begin
                  value_acc_next = acc_new;
                end else if (frac_taken < info.places) begin
                  value_acc_next  = acc_new;
                  frac_taken_next = frac_taken + 3'd1;
                end
              end else if (char_byte == CH_DOT && info.places != 3'd0 && !field_flags.dot) begin
                field_flags_next.dot = 1'b1;
              end else if ((char_byte == CH_MINUS || char_byte == CH_PLUS) && info.sgn
                           && char_position == 5'd0) begin
                if (char_byte == CH_MINUS) field_flags_next.neg = 1'b1;
              end else begin
                field_flags_next.bad = 1'b1;
              end
            end
            if (char_position != CNT_MAX) char_position_next = char_position + 5'd1;
          end else begin
            // end of line: commit on success and emit one result
            commit_ok = line_ok;
            if (line_ok) begin
              for (int k = 0; k < NUM_SLOTS; k++) begin
                if (used_mask[k]) kept_next[k] = pending[k];
              end
              if (used_mask[SLOT_LAT] && line_flags.hlat_s)
                kept_next[SLOT_LAT] = 32'd0 - pending[SLOT_LAT];
              if (used_mask[SLOT_LON] && line_flags.hlon_w)
                kept_next[SLOT_LON] = 32'd0 - pending[SLOT_LON];
            end
            push               = 1'b1;
            mode_next          = MODE_HDR;
            field_number_next  = '0;
            char_position_next = '0;
            degree_acc_next    = '0;
            value_acc_next     = '0;
            field_flags_next   = '0;
            frac_taken_next    = '0;
            first_char_next    = '0;
          end
        end
        default: begin
          // header match
          if (char_byte == CH_NL || !hdr_match(char_position, char_byte)) begin
            mode_next          = (char_byte == CH_NL) ? MODE_HDR : MODE_SKIP;
            char_position_next = '0;
          end else if (char_position == HDR_LAST) begin
            mode_next          = MODE_BODY;
            field_number_next  = '0;
            line_flags_next    = '0;
            present_mask_next  = '0;
            error_mask_next    = '0;
            char_position_next = '0;
            degree_acc_next    = '0;
            value_acc_next     = '0;
            field_flags_next   = '0;
            frac_taken_next    = '0;
            first_char_next    = '0;
          end else begin
            char_position_next = char_position + 5'd1;
          end
        end
      endcase
    end

    if (pos_rsp.valid) begin
      pending_next[pos_rsp.is_lon ? SLOT_LON : SLOT_LAT] = 32'(pos_rsp.mag);
    end

    result.ok    = commit_ok;
    result.lat   = kept_next[SLOT_LAT][30:0];
    result.lon   = kept_next[SLOT_LON];
    result.fix   = kept_next[SLOT_FIX][7:0];
    result.sat   = kept_next[SLOT_SAT][6:0];
    result.hdop  = kept_next[SLOT_HDOP][13:0];
    result.alt   = kept_next[SLOT_ALT][27:0];
    result.geoid = kept_next[SLOT_GEOID][20:0];
  end

  always_ff @(posedge clk) begin
    if (rst) mode <= MODE_HDR;
    else mode <= mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
      field_number  <= '0;
      degree_acc    <= '0;
      value_acc     <= '0;
      field_flags   <= '0;
      frac_taken    <= '0;
      first_char    <= '0;
      line_flags    <= '0;
      present_mask  <= '0;
      error_mask    <= '0;
      for (int k = 0; k < NUM_SLOTS; k++) kept[k] <= '0;
    end else begin
      char_position <= char_position_next;
      field_number  <= field_number_next;
      degree_acc    <= degree_acc_next;
      value_acc     <= value_acc_next;
      field_flags   <= field_flags_next;
      frac_taken    <= frac_taken_next;
      first_char    <= first_char_next;
      line_flags    <= line_flags_next;
      present_mask  <= present_mask_next;
      error_mask    <= error_mask_next;
      kept          <= kept_next;
    end
  end

  always_ff @(posedge clk) begin
    pending <= pending_next;
  end

endmodule

// ===== rtl/core/gga_result_fifo.sv =====
// Two-entry result queue between the parser core and the result channel.
// Depends on gga_pkg for the result word type.
module gga_result_fifo import gga_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  input  logic pop,
  output res_t head,
  output logic head_valid,
  output logic full
);

  res_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head       = entries[rd_ptr];
  assign head_valid = (count != 2'd0);
  assign full       = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

// ===== rtl/core/gga_sentence_parser_top.sv =====
// GGA sentence parser top level: character channel in, one result word per GGA line out.
// Depends on gga_pkg, gga_char_core, gga_pos_conv and gga_result_fifo.
//
// Usage:
//   Feed the receiver's byte stream on char_valid/char_ready/char_byte, one character
//   per word. Lines end at newline. Only lines opening with $GPGGA or $GNGGA count;
//   all other lines are dropped without a result.
//   At the newline of a counted line one result word appears on result_valid/
//   result_ready: parse_ok plus the kept fix values. The values advance only when
//   parse_ok is 1; empty fields hold their earlier values.
// Latency and throughput:
//   One character per cycle while char_ready is high. The result word for a newline
//   is valid the cycle after that newline is accepted. Latitude and longitude pass a
//   five-stage conversion pipeline (scale, multiply to 1e-7, divide by 60 via
//   reciprocal, add degrees and saturate); a well-formed line always carries enough
//   fields after them for the pipeline to finish before the newline.
// Stall:
//   Results queue in a two-word buffer. While one word waits the block keeps taking
//   characters; char_ready drops only when both words are waiting.
// Reset:
//   Synchronous, active high. Clears the line state, sets all kept values to zero
//   and empties the result buffer. No clearing pass; ready the cycle after reset.
module gga_sentence_parser_top import gga_pkg::*; #(
  parameter int FRACTION_DIGITS = DEF_FRAC
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_ready,
  input  logic [7:0]         char_byte,
  output logic               result_valid,
  input  logic               result_ready,
  output logic               parse_ok,
  output logic signed [30:0] lat_e7,
  output logic signed [31:0] lon_e7,
  output logic [7:0]         fix_kind,
  output logic [6:0]         sat_count,
  output logic [13:0]        hdop_centi,
  output logic signed [27:0] alt_cm,
  output logic signed [20:0] geoid_cm
);

  logic     fire;
  logic     push;
  logic     full;
  res_t     core_result;
  res_t     head;
  pos_req_t pos_req;
  pos_rsp_t pos_rsp;

  // take a character whenever the result buffer has a free word
  assign char_ready = !full;
  assign fire       = char_valid && char_ready;

  gga_char_core #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .char_byte (char_byte),
    .push      (push),
    .result    (core_result),
    .pos_req   (pos_req),
    .pos_rsp   (pos_rsp)
  );

  gga_pos_conv #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_pos_conv (
    .clk (clk),
    .rst (rst),
    .req (pos_req),
    .rsp (pos_rsp)
  );

  gga_result_fifo u_result_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (core_result),
    .pop        (result_valid && result_ready),
    .head       (head),
    .head_valid (result_valid),
    .full       (full)
  );

  assign parse_ok   = head.ok;
  assign lat_e7     = head.lat;
  assign lon_e7     = head.lon;
  assign fix_kind   = head.fix;
  assign sat_count  = head.sat;
  assign hdop_centi = head.hdop;
  assign alt_cm     = head.alt;
  assign geoid_cm   = head.geoid;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the GGA sentence parser (gga_sentence_parser_top).
// Holds its own line-by-line model of the parser and checks each result word against it.
// Depends on gga_pkg and the RTL of the block; reads nothing else.
`timescale 1ns / 1ps

module tb_top;
  import gga_pkg::*;

  localparam int          FRAC_DIGITS = DEF_FRAC;
  localparam int unsigned FRAC_PLACES = (FRAC_DIGITS > 7) ? 7 : FRAC_DIGITS;
  localparam int unsigned CYCLE_LIMIT = 500000;

  // Integer digits stop growing here; keeps the 64-bit arithmetic far from overflow.
  localparam longint unsigned NUM_CAP = 64'd100000000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        char_valid = 1'b0;
  logic        char_ready;
  logic [7:0]  char_byte = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic        parse_ok;
  logic signed [30:0] lat_e7;
  logic signed [31:0] lon_e7;
  logic [7:0]  fix_kind;
  logic [6:0]  sat_count;
  logic [13:0] hdop_centi;
  logic signed [27:0] alt_cm;
  logic signed [20:0] geoid_cm;

  // Both sides idle in random bursts while this is set; cleared for the last part.
  bit          idle_en = 1'b1;
  int unsigned fail_count = 0;
  int unsigned chars_sent = 0;
  int unsigned lines_counted = 0;
  int unsigned cycle_count = 0;

  // One entry per counted GGA line, in the order the newlines were accepted.
  res_t expected_fixes[$];

  string gp_hdr = "$GPGGA";
  string gn_hdr = "$GNGGA";

  // ---------------------------------------------------------------------------
  // Line tracker state: mirrors what the parser keeps between characters.
  // ---------------------------------------------------------------------------
  mode_t           line_st;
  int unsigned     fld_no;
  int unsigned     pos;
  int unsigned     deg_acc;
  int unsigned     frac_cnt;
  longint unsigned num_acc;
  bit              fw_bad, fw_dot, fw_neg, fw_dig;
  logic [7:0]      lead_char;
  bit              hdr_bad, has_ns, is_south, has_ew, is_west;
  logic [6:0]      present;
  logic [6:0]      errors;
  logic [31:0]     pending [7];
  logic [31:0]     kept    [7];

  gga_sentence_parser_top #(
    .FRACTION_DIGITS(FRAC_DIGITS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .char_byte   (char_byte),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .parse_ok    (parse_ok),
    .lat_e7      (lat_e7),
    .lon_e7      (lon_e7),
    .fix_kind    (fix_kind),
    .sat_count   (sat_count),
    .hdop_centi  (hdop_centi),
    .alt_cm      (alt_cm),
    .geoid_cm    (geoid_cm)
  );

  always #2 clk = ~clk;

  // Hard stop in case the block hangs on either channel.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("[gga_sentence_parser_top] ERROR");
      $finish;
    end
  end

  function automatic longint unsigned ten_pow(int unsigned n);
    longint unsigned r;
    r = 1;
    for (int i = 0; i < n; i++) r = r * 10;
    return r;
  endfunction

  // Which kept value a field number feeds, with its degree digits, fraction places
  // and whether a leading sign is legal.
  function automatic slot_t slot_of(int unsigned fn, output int unsigned deg,
                                    output int unsigned places, output bit sgn);
    deg    = 0;
    places = 2;
    sgn    = 1'b0;
    case (fn)
      FLD_LAT: begin
        deg = 2; places = FRAC_PLACES; return SLOT_LAT;
      end
      FLD_LON: begin
        deg = 3; places = FRAC_PLACES; return SLOT_LON;
      end
      FLD_FIX: begin
        places = 0; return SLOT_FIX;
      end
      FLD_SAT: begin
        places = 0; return SLOT_SAT;
      end
      FLD_HDOP: return SLOT_HDOP;
      FLD_ALT: begin
        sgn = 1'b1; return SLOT_ALT;
      end
      FLD_GEOID: begin
        sgn = 1'b1; return SLOT_GEOID;
      end
      default: return SLOT_NONE;
    endcase
  endfunction

  function automatic void open_field();
    pos       = 0;
    deg_acc   = 0;
    num_acc   = 0;
    frac_cnt  = 0;
    lead_char = '0;
    fw_bad    = 1'b0;
    fw_dot    = 1'b0;
    fw_neg    = 1'b0;
    fw_dig    = 1'b0;
  endfunction

  function automatic void reset_tracker();
    line_st = MODE_HDR;
    fld_no  = 0;
    open_field();
    hdr_bad  = 1'b0;
    has_ns   = 1'b0;
    is_south = 1'b0;
    has_ew   = 1'b0;
    is_west  = 1'b0;
    present  = '0;
    errors   = '0;
    for (int k = 0; k < 7; k++) begin
      pending[k] = '0;
      kept[k]    = '0;
    end
  endfunction

  // Accumulate one non-separator character of the current field.
  function automatic void take_char(logic [7:0] c);
    int unsigned deg, places;
    bit          sgn, digit;
    slot_t       s;
    s     = slot_of(fld_no, deg, places, sgn);
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    // Anything after the six header characters spoils the header field.
    if (fld_no == FLD_HDR) hdr_bad = 1'b1;
    if (pos == 0) lead_char = c;
    if (s != SLOT_NONE) begin
      if (pos < deg) begin
        if (digit) deg_acc = deg_acc * 10 + (c - CH_ZERO);
        else fw_bad = 1'b1;
      end else if (digit) begin
        fw_dig = 1'b1;
        if (!fw_dot) begin
          num_acc = num_acc * 10 + (c - CH_ZERO);
          if (num_acc > NUM_CAP) num_acc = NUM_CAP;
        end else if (frac_cnt < places) begin
          // Fraction digits past the kept places are dropped.
          num_acc = num_acc * 10 + (c - CH_ZERO);
          frac_cnt++;
        end
      end else if (c == CH_DOT && places > 0 && !fw_dot) begin
        fw_dot = 1'b1;
      end else if ((c == CH_MINUS || c == CH_PLUS) && sgn && pos == 0) begin
        if (c == CH_MINUS) fw_neg = 1'b1;
      end else begin
        fw_bad = 1'b1;
      end
    end
    if (pos < 31) pos++;
  endfunction

  // Finish a field at a comma or newline: record hemispheres, or convert a number
  // into its candidate value.
  function automatic void close_field();
    int unsigned     deg, places;
    bit              sgn;
    slot_t           s;
    longint unsigned v, unit, m, lim;
    if (pos == 0) return;
    if (fld_no == FLD_NS) begin
      has_ns = 1'b1;
      if (pos == 1 && lead_char == CH_S) is_south = 1'b1;
      return;
    end
    if (fld_no == FLD_EW) begin
      has_ew = 1'b1;
      if (pos == 1 && lead_char == CH_W) is_west = 1'b1;
      return;
    end
    s = slot_of(fld_no, deg, places, sgn);
    if (s == SLOT_NONE) return;
    present[s] = 1'b1;
    if (fw_bad || !fw_dig) errors[s] = 1'b1;
    v = num_acc * ten_pow(places - frac_cnt);
    if (s == SLOT_LAT || s == SLOT_LON) begin
      // Minutes clamp at 100, then degrees plus minutes/60 rounded half up.
      unit = ten_pow(places);
      m    = (v > 100 * unit) ? 100 * unit : v;
      lim  = (s == SLOT_LAT) ? 64'd900000000 : 64'd1800000000;
      v    = deg_acc * 64'd10000000 + (m * 64'd10000000 + 30 * unit) / (60 * unit);
      if (v > lim) v = lim;
      pending[s] = v[31:0];
      return;
    end
    case (s)
      SLOT_FIX:  lim = 255;
      SLOT_SAT:  lim = 99;
      SLOT_HDOP: lim = 9999;
      SLOT_ALT:  lim = 100000000;
      default:   lim = 1000000;
    endcase
    if (v > lim) v = lim;
    pending[s] = fw_neg ? -v[31:0] : v[31:0];
  endfunction

  // Advance the tracker by one accepted character; queue the result word that a
  // newline of a counted line produces.
  function automatic void track_char(logic [7:0] c);
    int unsigned tokens;
    bit          ok;
    logic [6:0]  used;
    res_t        r;
    int          k;
    case (line_st)
      MODE_SKIP: begin
        if (c == CH_NL) begin
          line_st = MODE_HDR;
          pos     = 0;
        end
      end
      MODE_HDR: begin
        if (c == CH_NL || pos > HDR_LAST || (c != gp_hdr[pos] && c != gn_hdr[pos])) begin
          line_st = (c == CH_NL) ? MODE_HDR : MODE_SKIP;
          pos     = 0;
        end else if (pos == HDR_LAST) begin
          line_st  = MODE_BODY;
          fld_no   = 0;
          hdr_bad  = 1'b0;
          has_ns   = 1'b0;
          is_south = 1'b0;
          has_ew   = 1'b0;
          is_west  = 1'b0;
          present  = '0;
          errors   = '0;
          open_field();
        end else begin
          pos++;
        end
      end
      default: begin
        if (c == CH_COMMA) begin
          close_field();
          if (fld_no < CNT_MAX) fld_no++;
          open_field();
        end else if (c != CH_NL) begin
          take_char(c);
        end else begin
          tokens = fld_no + ((pos > 0) ? 1 : 0);
          close_field();
          // A position only counts together with its hemisphere field.
          used = present & 7'h7C;
          if (present[SLOT_LAT] && has_ns) used[SLOT_LAT] = 1'b1;
          if (present[SLOT_LON] && has_ew) used[SLOT_LON] = 1'b1;
          ok = !hdr_bad && tokens >= MIN_FIELDS && (used & errors) == '0;
          if (ok) begin
            for (k = 0; k < 7; k++) begin
              if (used[k]) kept[k] = pending[k];
            end
            if (used[SLOT_LAT] && is_south) kept[SLOT_LAT] = -pending[SLOT_LAT];
            if (used[SLOT_LON] && is_west)  kept[SLOT_LON] = -pending[SLOT_LON];
          end
          r.ok    = ok;
          r.lat   = kept[SLOT_LAT][30:0];
          r.lon   = kept[SLOT_LON];
          r.fix   = kept[SLOT_FIX][7:0];
          r.sat   = kept[SLOT_SAT][6:0];
          r.hdop  = kept[SLOT_HDOP][13:0];
          r.alt   = kept[SLOT_ALT][27:0];
          r.geoid = kept[SLOT_GEOID][20:0];
          expected_fixes.push_back(r);
          lines_counted++;
          line_st = MODE_HDR;
          fld_no  = 0;
          open_field();
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts on result_ready, and the word checker.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold--;
        result_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 8);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Outputs are sampled right after the edge, before any update of that edge lands.
  always @(posedge clk) begin
    res_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_fixes.size() == 0) begin
        $display("%0t: result word with no counted line pending", $time);
        fail_count++;
      end else begin
        want = expected_fixes.pop_front();
        check_field("parse_ok",   want.ok,    parse_ok);
        check_field("lat_e7",     want.lat,   $unsigned(lat_e7));
        check_field("lon_e7",     want.lon,   $unsigned(lon_e7));
        check_field("fix_kind",   want.fix,   fix_kind);
        check_field("sat_count",  want.sat,   sat_count);
        check_field("hdop_centi", want.hdop,  hdop_centi);
        check_field("alt_cm",     want.alt,   $unsigned(alt_cm));
        check_field("geoid_cm",   want.geoid, $unsigned(geoid_cm));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Character side.
  // ---------------------------------------------------------------------------

  // Send one character word. Called at a rising edge; returns at the edge that
  // accepted it. Valid only drops for an idle burst, never between two words
  // in the same step.
  task automatic send_char(input logic [7:0] c);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      char_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_byte  <= c;
    do @(posedge clk); while (!char_ready);
    chars_sent++;
    track_char(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Hold off the sender until every pending result word has been taken.
  task automatic wait_drained();
    while (expected_fixes.size() != 0) @(posedge clk);
  endtask

  // Standard 15-field GGA line with the numeric fields given.
  function automatic string gga(input string hdr, lat, ns, lon, ew, fix, sat, hdop,
                                alt, geo);
    return {hdr, ",123519,", lat, ",", ns, ",", lon, ",", ew, ",", fix, ",", sat, ",",
            hdop, ",", alt, ",M,", geo, ",M,,*47\n"};
  endfunction

  function automatic string digits(input int unsigned n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    return s;
  endfunction

  // Now and then spoil one character of a field.
  function automatic string mutate(input string s);
    string junk;
    junk = "+-.Z# ";
    if (s.len() > 0 && $urandom_range(0, 14) == 0)
      s.putc($urandom_range(0, s.len() - 1), junk[$urandom_range(0, 5)]);
    return s;
  endfunction

  function automatic string random_number(input int unsigned int_max, frac_max,
                                          input bit sgn_ok);
    string s;
    if ($urandom_range(0, 5) == 0) return "";
    s = "";
    if (sgn_ok && $urandom_range(0, 2) == 0) s = $urandom_range(0, 1) ? "-" : "+";
    // Mostly short numbers, sometimes long ones that must saturate.
    s = {s, digits($urandom_range(1, ($urandom_range(0, 9) == 0) ? 13 : int_max))};
    if (frac_max > 0 && $urandom_range(0, 2) != 0)
      s = {s, ".", digits($urandom_range(0, frac_max))};
    return mutate(s);
  endfunction

  function automatic string random_position(input int unsigned deg_digits);
    string s;
    if ($urandom_range(0, 7) == 0) return "";
    s = {digits(deg_digits), digits(2)};
    if ($urandom_range(0, 9) == 0) s = {s, digits($urandom_range(1, 3))};
    if ($urandom_range(0, 3) != 0) s = {s, ".", digits($urandom_range(0, 9))};
    return mutate(s);
  endfunction

  function automatic string random_hemi(input string plus, minus);
    case ($urandom_range(0, 7))
      0, 1, 2: return plus;
      3, 4, 5: return minus;
      6:       return "";
      default: return $urandom_range(0, 1) ? {minus, minus} : "s";
    endcase
  endfunction

  // Mostly well-formed GGA lines with random content; some with too few or too
  // many fields, a spoiled header or a trailing carriage return.
  function automatic string random_sentence();
    string       f[$];
    string       s;
    int unsigned n;
    f.push_back($urandom_range(0, 1) ? gp_hdr : gn_hdr);
    if ($urandom_range(0, 19) == 0) f[0] = {f[0], "Z"};
    f.push_back($urandom_range(0, 3) ? digits(6) : "");
    f.push_back(random_position(2));
    f.push_back(random_hemi("N", "S"));
    f.push_back(random_position(3));
    f.push_back(random_hemi("E", "W"));
    f.push_back(random_number(3, 0, 1'b0));
    f.push_back(random_number(3, 0, 1'b0));
    f.push_back(random_number(4, 3, 1'b0));
    f.push_back(random_number(7, 4, 1'b1));
    f.push_back("M");
    f.push_back(random_number(6, 3, 1'b1));
    f.push_back("M");
    f.push_back("");
    f.push_back($urandom_range(0, 7) ? $sformatf("*%02X", $urandom_range(0, 255)) : "");
    case ($urandom_range(0, 9))
      0: begin
        n = $urandom_range(1, 14);
        while (f.size() > n) void'(f.pop_back());
      end
      1: begin
        n = $urandom_range(16, 40);
        while (f.size() < n) f.push_back($urandom_range(0, 1) ? digits(2) : "");
      end
      default: ;
    endcase
    s = f[0];
    for (int i = 1; i < f.size(); i++) s = {s, ",", f[i]};
    if ($urandom_range(0, 7) == 0) s = {s, "\r"};
    return {s, "\n"};
  endfunction

  // Lines that are mostly dropped: raw bytes, header prefixes, cut sentences.
  task automatic send_noise();
    int unsigned n;
    string       s;
    case ($urandom_range(0, 3))
      0: begin
        n = $urandom_range(1, 20);
        repeat (n) send_char($urandom_range(0, 255));
        send_char(CH_NL);
      end
      1: begin
        n = $urandom_range(0, 5);
        send_text({gp_hdr.substr(0, n - 1), "\n"});
      end
      2: begin
        send_text(gn_hdr);
        repeat ($urandom_range(1, 30)) send_char($urandom_range(0, 255));
        send_char(CH_NL);
      end
      default: begin
        s = random_sentence();
        send_text({s.substr(0, $urandom_range(0, s.len() - 2)), "\n"});
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Textbook sentence, everything present and well formed.
  task automatic test_reference_sentence();
    send_text(gga(gp_hdr, "4807.038", "N", "01131.000", "E", "1", "08", "0.9", "545.4",
                  "46.9"));
  endtask

  // Range ends, saturation of every value, negative zero, hemisphere rules.
  task automatic test_value_limits();
    send_text(gga(gn_hdr, "9000.00000", "S", "18000.00000", "W", "255", "99", "99.99",
                  "-1000000.00", "-10000.00"));
    send_text(gga(gp_hdr, "9959.9999999", "S", "99999.99999999", "W", "999", "100",
                  "123456.789", "+99999999999999", "-99999999"));
    send_text(gga(gp_hdr, "0000.0", "N", "00000.00000", "E", "0", "00", "0.00", "-0",
                  "0.0"));
    // Hemisphere must be exactly S or W to negate; extra fraction digits dropped.
    send_text(gga(gn_hdr, "5930.123456789", "s", "12345.6", "WW", "4", "12", "1.5",
                  "+12.345", "-0.999"));
    // Positions without a hemisphere are not used; kept values hold.
    send_text(gga(gp_hdr, "1234.5", "", "12345.6", "", "2", "7", "2", "3", "4"));
  endtask

  // Counted and dropped lines decided by the first six characters.
  task automatic test_header_forms();
    send_text(gga("$GPGGAX", "4807.038", "N", "01131.000", "E", "1", "08", "0.9", "1",
                  "2"));
    send_text("$GPGGA\n");
    send_text("$GPGG\n");
    send_text("$GXGGA,1,2,3\n");
    send_text("\n");
    send_text("$$GPGGA,,,,,,,,,,,,,,,\n");
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_NL);
  endtask

  // Field count threshold, and lines long enough to saturate the counters.
  task automatic test_field_count();
    string s;
    send_text("$GPGGA,,,,,,,,,,,,,\n");
    send_text("$GPGGA,,,,,,,,,,,,,,\n");
    send_text("$GNGGA,,,,,,,,,,,,,,*5A\n");
    s = gga(gp_hdr, {"4500.", digits(40)}, "S", {"017", digits(35)}, "W", "3",
            digits(33), digits(40), {"-", digits(38)}, "12");
    send_text({s.substr(0, s.len() - 2), ",,,,,,,,,,,,,,,,,,,,,,,,,", digits(36), "\n"});
  endtask

  // Malformed numbers in used fields fail the line; in unused ones they do not.
  task automatic test_number_syntax();
    string s;
    send_text(gga(gp_hdr, "4807.038", "N", "01131.000", "E", "1", "08", "1+2", "5", "6"));
    send_text(gga(gp_hdr, "4807.038", "N", "01131.000", "E", "1", "8.0", "0.9", "5", "6"));
    send_text(gga(gp_hdr, "4807.038", "N", "01131.000", "E", "+1", "08", "0.9", "5", "6"));
    send_text(gga(gp_hdr, "4807.038", "N", "01131.000", "E", "1", "08", "0.9", "-", "6"));
    send_text(gga(gp_hdr, "4807.038", "N", "01131.000", "E", "1", "08", "0.9", "5",
                  "1.2.3"));
    send_text(gga(gp_hdr, "4.5", "N", "01131.000", "E", "1", "08", "0.9", "5", "6"));
    send_text(gga(gp_hdr, "48", "N", "01131.000", "E", "1", "08", "0.9", "5", "6"));
    send_text(gga(gp_hdr, "xx", "", "01131.000", "E", "1", "08", "0.9", "5", "6"));
    send_text(gga(gp_hdr, "4807.038", "N", "01131.000", "E", "1", "08", "0.9", "12-3",
                  "6"));
    send_text(gga(gp_hdr, "4807.038", "N", "01131.000", "E", "1", "08", "0.9\r", "5",
                  "6"));
    // Carriage return in the last field is just part of that field.
    s = gga(gn_hdr, "3300.5", "S", "15112.25", "E", "2", "11", "1.25", "-3.5", "-21.5");
    send_text({s.substr(0, s.len() - 2), "\r\n"});
  endtask

  // All-empty line holds everything; then pause until drained before a partial update.
  task automatic test_held_values();
    send_text(gga(gp_hdr, "", "", "", "", "", "", "", "", ""));
    wait_drained();
    send_text(gga(gn_hdr, "0130.5", "N", "", "E", "", "", "", "", "-5"));
  endtask

  task automatic test_random_traffic(input int unsigned min_chars, min_lines);
    int unsigned c0, l0;
    c0 = chars_sent;
    l0 = lines_counted;
    while (chars_sent - c0 < min_chars || lines_counted - l0 < min_lines) begin
      if ($urandom_range(0, 3) == 0) send_noise();
      else send_text(random_sentence());
    end
  endtask

  initial begin
    reset_tracker();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reference_sentence();
    test_value_limits();
    test_header_forms();
    test_field_count();
    test_number_syntax();
    test_held_values();
    test_random_traffic(800, 50);
    // Last stretch runs at full rate on both sides.
    idle_en = 1'b0;
    test_random_traffic(250, 12);

    char_valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[gga_sentence_parser_top] OK");
    end else begin
      $display("[gga_sentence_parser_top] ERROR");
    end
    $finish;
  end

endmodule
